[src/bmsi_pkg.sv]
// types and constants of the bank mapper with scanline irq
// no dependencies; used by every module of the block except bmsi_fifo
package bmsi_pkg;

  localparam int unsigned BANK_W  = 8;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CHR_REGS = 6;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_PRG   = 2'd2,
    KIND_CHR   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRG_BANKS   = 2'd0,
    CFG_FOUR_SCREEN = 2'd1,
    CFG_IRQ_NEW     = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_BANK_SELECT,
    OP_BANK_DATA,
    OP_MIRROR,
    OP_WRAM,
    OP_IRQ_LATCH,
    OP_IRQ_RELOAD,
    OP_IRQ_DISABLE,
    OP_IRQ_ENABLE,
    OP_TICK,
    OP_PRG,
    OP_CHR
  } op_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data;
  } in_item_t;

  typedef struct packed {
    logic [BANK_W-1:0] mapped_bank;
    logic              irq_line;
    logic              mirror_horizontal;
    logic              wram_enable;
    logic              wram_protect;
  } out_item_t;

  // decoded item between front and back
  typedef struct packed {
    op_t        op;
    logic [2:0] win;
    logic [7:0] data;
  } dec_item_t;

  typedef struct packed {
    logic [7:0] prg_rom_16k_banks;
    logic       four_screen;
    logic       irq_new_style;
  } cfg_t;

endpackage

[src/bmsi_fifo.sv]
// small register queue with simultaneous push and pop
// generic width and depth; no package dependency
module bmsi_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue count beyond depth");
  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not grow queue");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not shrink queue");

endmodule

[src/bmsi_front.sv]
// front end: classifies an incoming item into a decoded operation
// depends on bmsi_pkg
module bmsi_front (
  input  bmsi_pkg::in_item_t  item,
  output bmsi_pkg::dec_item_t dec
);
  import bmsi_pkg::*;

  always_comb begin
    dec.win  = 3'd0;
    dec.data = item.data;
    dec.op   = OP_NONE;
    unique case (kind_t'(item.kind))
      KIND_WRITE: begin
        if (item.address[15]) begin
          unique case ({item.address[14:13], item.address[0]})
            3'b000: dec.op = OP_BANK_SELECT;
            3'b001: dec.op = OP_BANK_DATA;
            3'b010: dec.op = OP_MIRROR;
            3'b011: dec.op = OP_WRAM;
            3'b100: dec.op = OP_IRQ_LATCH;
            3'b101: dec.op = OP_IRQ_RELOAD;
            3'b110: dec.op = OP_IRQ_DISABLE;
            3'b111: dec.op = OP_IRQ_ENABLE;
            default: dec.op = OP_NONE;
          endcase
        end
      end
      KIND_TICK: dec.op = OP_TICK;
      KIND_PRG: begin
        if (item.address[15]) begin
          dec.op  = OP_PRG;
          dec.win = {1'b0, item.address[14:13]};
        end
      end
      KIND_CHR: begin
        if (item.address[15:13] == 3'b000) begin
          dec.op  = OP_CHR;
          dec.win = item.address[12:10];
        end
      end
      default: dec.op = OP_NONE;
    endcase
  end

endmodule

[src/bmsi_back.sv]
// back end: holds mapper and irq state, executes decoded items
// depends on bmsi_pkg
module bmsi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bmsi_pkg::cfg_t      cfg,
  input  logic                fire,
  input  bmsi_pkg::dec_item_t dec,
  output bmsi_pkg::out_item_t res
);
  import bmsi_pkg::*;

  logic [7:0] bank_select_r, bank_select_nxt;
  logic [7:0] chr_r [CHR_REGS];
  logic [7:0] chr_nxt [CHR_REGS];
  logic [7:0] r6_r, r6_nxt, r7_r, r7_nxt;
  logic [7:0] counter_r, counter_nxt, latch_r, latch_nxt;
  logic       reload_r, reload_nxt, enabled_r, enabled_nxt;
  logic       asserted_r, asserted_nxt;
  logic       mirror_r, mirror_nxt, wram_on_r, wram_on_nxt, wram_deny_r, wram_deny_nxt;

  logic [7:0] last_bank, penult_bank, prg_sel, chr_sel, bank;
  logic [2:0] slot, chr_idx;
  logic       do_reload;

  assign last_bank   = {cfg.prg_rom_16k_banks[6:0], 1'b0} - 8'd1;
  assign penult_bank = last_bank - 8'd1;

  always_comb begin
    unique case (dec.win[1:0])
      2'd0:    prg_sel = bank_select_r[6] ? penult_bank : r6_r;
      2'd1:    prg_sel = r7_r;
      2'd2:    prg_sel = bank_select_r[6] ? r6_r : penult_bank;
      default: prg_sel = last_bank;
    endcase
  end

  // a12 inversion swaps the two pattern table halves
  assign slot    = dec.win ^ {bank_select_r[7], 2'b00};
  assign chr_idx = slot[2] ? slot - 3'd2 : {2'b00, slot[1]};
  assign chr_sel = chr_r[chr_idx] + {7'd0, ~slot[2] & slot[0]};

  always_comb begin
    unique case (dec.op)
      OP_PRG:  bank = prg_sel;
      OP_CHR:  bank = chr_sel;
      default: bank = 8'd0;
    endcase
  end

  assign do_reload = reload_r || (counter_r == 8'd0);

  always_comb begin
    bank_select_nxt = bank_select_r;
    for (int i = 0; i < CHR_REGS; i++) chr_nxt[i] = chr_r[i];
    r6_nxt        = r6_r;
    r7_nxt        = r7_r;
    counter_nxt   = counter_r;
    latch_nxt     = latch_r;
    reload_nxt    = reload_r;
    enabled_nxt   = enabled_r;
    asserted_nxt  = asserted_r;
    mirror_nxt    = mirror_r;
    wram_on_nxt   = wram_on_r;
    wram_deny_nxt = wram_deny_r;
    unique case (dec.op)
      OP_BANK_SELECT: bank_select_nxt = dec.data;
      OP_BANK_DATA: begin
        unique case (bank_select_r[2:0])
          3'd0, 3'd1: chr_nxt[bank_select_r[2:0]] = {dec.data[7:1], 1'b0};
          3'd6:       r6_nxt = dec.data;
          3'd7:       r7_nxt = dec.data;
          default:    chr_nxt[bank_select_r[2:0]] = dec.data;
        endcase
      end
      OP_MIRROR: begin
        if (!cfg.four_screen) begin
          mirror_nxt = dec.data[0];
        end
      end
      OP_WRAM: begin
        wram_on_nxt   = dec.data[7];
        wram_deny_nxt = dec.data[6];
      end
      OP_IRQ_LATCH: latch_nxt = dec.data;
      OP_IRQ_RELOAD: begin
        reload_nxt  = 1'b1;
        counter_nxt = 8'd0;
      end
      OP_IRQ_DISABLE: begin
        enabled_nxt  = 1'b0;
        asserted_nxt = 1'b0;
      end
      OP_IRQ_ENABLE: enabled_nxt = 1'b1;
      OP_TICK: begin
        counter_nxt = do_reload ? latch_r : counter_r - 8'd1;
        reload_nxt  = 1'b0;
        if (enabled_r && counter_nxt == 8'd0 && (cfg.irq_new_style || !do_reload)) begin
          asserted_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res.mapped_bank       = bank;
  assign res.irq_line          = asserted_nxt;
  assign res.mirror_horizontal = mirror_nxt;
  assign res.wram_enable       = wram_on_nxt;
  assign res.wram_protect      = wram_deny_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_select_r <= '0;
      for (int i = 0; i < CHR_REGS; i++) chr_r[i] <= '0;
      r6_r        <= '0;
      r7_r        <= '0;
      counter_r   <= '0;
      latch_r     <= '0;
      reload_r    <= 1'b0;
      enabled_r   <= 1'b0;
      asserted_r  <= 1'b0;
      mirror_r    <= 1'b0;
      wram_on_r   <= 1'b0;
      wram_deny_r <= 1'b0;
    end else if (fire) begin
      bank_select_r <= bank_select_nxt;
      for (int i = 0; i < CHR_REGS; i++) chr_r[i] <= chr_nxt[i];
      r6_r        <= r6_nxt;
      r7_r        <= r7_nxt;
      counter_r   <= counter_nxt;
      latch_r     <= latch_nxt;
      reload_r    <= reload_nxt;
      enabled_r   <= enabled_nxt;
      asserted_r  <= asserted_nxt;
      mirror_r    <= mirror_nxt;
      wram_on_r   <= wram_on_nxt;
      wram_deny_r <= wram_deny_nxt;
    end
  end

  a_irq_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && dec.op == OP_IRQ_DISABLE) |=> !asserted_r && !enabled_r)
    else $error("irq not cleared by acknowledge");
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && dec.op == OP_IRQ_RELOAD) |=> reload_r && counter_r == 8'd0)
    else $error("reload request lost");
  a_chr_even: assert property (@(posedge clk) disable iff (!rst_n)
    !chr_r[0][0] && !chr_r[1][0]) else $error("2k chr bank is odd");
  a_irq_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(asserted_r)) else $error("irq changed without an item");

endmodule

[src/bank_mapper_with_scanline_irq_unit.sv]
// top level of the cartridge bank mapper with scanline irq counter
// depends on bmsi_pkg, bmsi_front, bmsi_back and bmsi_fifo
//
// usage:
//   input channel: an item (kind, address, data) is taken when in_push is high
//   and in_full is low. kinds are a cpu register write, an a12 rise tick, a prg
//   translation and a chr translation.
//   result channel: while out_empty is low, out_item holds the oldest result
//   (mapped bank, irq line, mirroring, wram flags); out_pop takes it.
//   config port: cfg_we writes cfg_wdata into the register cfg_index (prg rom
//   size, four screen, irq style); the user must write it only while the block is idle, the block does not enforce it.
// timing:
//   the front classifies an item in the cycle it is taken and queues it in the
//   decode queue; the back executes one queued item per cycle while the result
//   queue has room and registers its result there. one item per cycle sustained
//   while results are popped. a stalled receiver fills the result queue, then
//   the decode queue, then raises in_full; nothing is dropped.
// reset: synchronous rst_n clears all mapper state and both queues and loads
//   the config defaults (2 prg units, no four screen, new irq style).
module bank_mapper_with_scanline_irq_unit #(
  parameter int unsigned DEC_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  bmsi_pkg::in_item_t                  in_item,
  output logic                                in_full,
  output logic                                out_empty,
  input  logic                                out_pop,
  output bmsi_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [bmsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmsi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bmsi_pkg::*;

  cfg_t      cfg_r;
  dec_item_t front_dec, back_dec;
  out_item_t back_res;
  logic      dec_empty, res_full, fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prg_rom_16k_banks <= 8'd2;
      cfg_r.four_screen       <= 1'b0;
      cfg_r.irq_new_style     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PRG_BANKS:   cfg_r.prg_rom_16k_banks <= cfg_wdata;
        CFG_FOUR_SCREEN: cfg_r.four_screen       <= cfg_wdata[0];
        CFG_IRQ_NEW:     cfg_r.irq_new_style     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  bmsi_front u_front (
    .item (in_item),
    .dec  (front_dec)
  );

  bmsi_fifo #(
    .WIDTH ($bits(dec_item_t)),
    .DEPTH (DEC_DEPTH)
  ) u_dec_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_dec),
    .full  (in_full),
    .pop   (fire),
    .rdata (back_dec),
    .empty (dec_empty)
  );

  assign fire = !dec_empty && !res_full;

  bmsi_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (fire),
    .dec   (back_dec),
    .res   (back_res)
  );

  bmsi_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fire),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

  a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !res_full && !dec_empty) else $error("execute without room");
  a_cfg_default: assert property (@(posedge clk)
    !rst_n |=> cfg_r.prg_rom_16k_banks == 8'd2 && cfg_r.irq_new_style)
    else $error("config reset value wrong");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_full && !out_pop) |=> $stable(out_item)) else $error("result lost on stall");

endmodule
